FILE: sv/gda_pkg.sv
package gda_pkg;

    // Year limits of the stored date
    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [8:0]  YEAR_DAYS  = 9'd365;

    // Exact divisibility by 25: y * inv(25) mod 2^14 lands in 0..655 only for multiples
    localparam logic [12:0] INV25      = 13'd7209;
    localparam logic [13:0] DIV25_MAX  = 14'd655;

    // Sequencer step addresses
    localparam logic [3:0] STEP_FETCH  = 4'd0;
    localparam logic [3:0] STEP_DISP   = 4'd1;
    localparam logic [3:0] STEP_SET    = 4'd2;
    localparam logic [3:0] STEP_DOY    = 4'd3;
    localparam logic [3:0] STEP_BDEC   = 4'd4;
    localparam logic [3:0] STEP_BADD   = 4'd5;
    localparam logic [3:0] STEP_FWD    = 4'd6;
    localparam logic [3:0] STEP_MON    = 4'd7;
    localparam logic [3:0] STEP_COMMIT = 4'd8;
    localparam logic [3:0] STEP_EMIT   = 4'd9;

    // Datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_FETCH    = 4'd1;
    localparam logic [3:0] OP_SET      = 4'd2;
    localparam logic [3:0] OP_DOY      = 4'd3;
    localparam logic [3:0] OP_BDEC     = 4'd4;
    localparam logic [3:0] OP_BADD     = 4'd5;
    localparam logic [3:0] OP_FWD      = 4'd6;
    localparam logic [3:0] OP_MON      = 4'd7;
    localparam logic [3:0] OP_COMMIT   = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;

    // Jump conditions
    localparam logic [2:0] C_ALWAYS    = 3'd0;
    localparam logic [2:0] C_IN        = 3'd1;
    localparam logic [2:0] C_REQ       = 3'd2;
    localparam logic [2:0] C_DNEG      = 3'd3;
    localparam logic [2:0] C_BLOOP     = 3'd4;
    localparam logic [2:0] C_FGT       = 3'd5;
    localparam logic [2:0] C_MGT       = 3'd6;
    localparam logic [2:0] C_OUTFREE   = 3'd7;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] jt;
        logic [3:0] jf;
    } t_uword;

    // 4/100/400 rule without a divider
    function automatic logic f_is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [13:0] p;
        logic        div25;
        prod  = 27'(y) * 27'(INV25);
        p     = prod[13:0];
        div25 = (p <= DIV25_MAX);
        // for a multiple of 25, p is y/25; y%400==0 iff that quotient is a multiple of 16
        return (y[1:0] == 2'b00) && (!div25 || (p[3:0] == 4'd0));
    endfunction

    // Month length, zero for a month code outside 1..12
    function automatic logic [4:0] f_mlen(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of month m in a common year
    function automatic logic [8:0] f_cum(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Control store
    function automatic t_uword f_ucode(input logic [3:0] pc);
        t_uword w;
        case (pc)
            STEP_FETCH:  w = '{OP_FETCH,  C_IN,      STEP_DISP,  STEP_FETCH};
            STEP_DISP:   w = '{OP_NOP,    C_REQ,     STEP_DOY,   STEP_SET};
            STEP_SET:    w = '{OP_SET,    C_ALWAYS,  STEP_EMIT,  STEP_EMIT};
            STEP_DOY:    w = '{OP_DOY,    C_ALWAYS,  STEP_BDEC,  STEP_BDEC};
            STEP_BDEC:   w = '{OP_BDEC,   C_DNEG,    STEP_BADD,  STEP_FWD};
            STEP_BADD:   w = '{OP_BADD,   C_BLOOP,   STEP_BADD,  STEP_FWD};
            STEP_FWD:    w = '{OP_FWD,    C_FGT,     STEP_FWD,   STEP_MON};
            STEP_MON:    w = '{OP_MON,    C_MGT,     STEP_MON,   STEP_COMMIT};
            STEP_COMMIT: w = '{OP_COMMIT, C_ALWAYS,  STEP_EMIT,  STEP_EMIT};
            STEP_EMIT:   w = '{OP_EMIT,   C_OUTFREE, STEP_FETCH, STEP_EMIT};
            default:     w = '{OP_NOP,    C_ALWAYS,  STEP_FETCH, STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/gda_if.sv
// Request channel
interface gda_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [13:0]        set_year;
    logic [3:0]         set_month;
    logic [4:0]         set_day;
    logic signed [16:0] day_offset;

    modport source (output valid, req_type, set_year, set_month, set_day, day_offset,
                    input ready);
    modport sink   (input valid, req_type, set_year, set_month, set_day, day_offset,
                    output ready);
endinterface

// Result channel
interface gda_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic        accepted;

    modport source (output valid, cur_year, cur_month, cur_day, accepted, input ready);
    modport sink   (input valid, cur_year, cur_month, cur_day, accepted, output ready);
endinterface

FILE: sv/gregorian_date_advance.sv
// Channel  Dir  Payload                                         Handshake
// i_req    in   req_type, set_year, set_month, set_day,         valid/ready
//               day_offset
// o_rsp    out  cur_year, cur_month, cur_day, accepted          valid/ready
//
// One item at a time, run by a ten-step microcode sequencer.
// FETCH, DISP, then set: SET, EMIT; advance: DOY, BDEC, BADD/FWD, MON, COMMIT, EMIT.
// The year loop takes one cycle per year, paced by the leap-bit register behind it.
// Reset loads 0001-01-01; a result waiting on o_rsp does not block the next input item.
module gregorian_date_advance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_req,
    gda_out_if.source o_rsp
);

    // Sequencer and stored date
    logic [3:0]         r_pc,    n_pc;
    logic               r_ok,    n_ok;
    logic               r_ov,    n_ov;
    logic [13:0]        r_year,  n_year;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_day,   n_day;

    // Working registers
    logic               r_req,   n_req;
    logic [3:0]         r_sm,    n_sm;
    logic [4:0]         r_sd,    n_sd;
    logic signed [16:0] r_off,   n_off;
    logic [13:0]        r_wy,    n_wy;
    logic [3:0]         r_wm,    n_wm;
    logic signed [17:0] r_days,  n_days;
    logic               r_leap;

    // Output register
    logic [13:0]        r_oyear, n_oyear;
    logic [3:0]         r_omon,  n_omon;
    logic [4:0]         r_oday,  n_oday;
    logic               r_oacc,  n_oacc;

    gda_pkg::t_uword    w_uw;
    logic [8:0]         w_ylen;
    logic [4:0]         w_mlen;
    logic [4:0]         w_set_mlen;
    logic               w_set_ok;
    logic [9:0]         w_doy;
    logic signed [17:0] w_ylen_s;
    logic signed [17:0] w_mlen_s;
    logic signed [17:0] w_days_n;
    logic               w_in_acc;
    logic               w_cond;
    logic               w_fail;

    assign w_uw       = gda_pkg::f_ucode(r_pc);
    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_ylen     = gda_pkg::YEAR_DAYS + 9'(r_leap);
    assign w_mlen     = gda_pkg::f_mlen(r_wm, r_leap);
    assign w_ylen_s   = $signed({9'd0, w_ylen});
    assign w_mlen_s   = $signed({13'd0, w_mlen});
    assign w_days_n   = r_days + w_ylen_s;
    assign w_set_mlen = gda_pkg::f_mlen(r_sm, r_leap);
    assign w_set_ok   = (r_wy >= gda_pkg::YEAR_MIN) && (r_wy <= gda_pkg::YEAR_MAX)
                        && (r_sd != 5'd0) && (r_sd <= w_set_mlen);
    assign w_doy      = 10'(gda_pkg::f_cum(r_month)) + 10'(r_day)
                        + 10'(r_leap && (r_month > 4'd2));

    // Jump condition select
    always_comb begin
        case (w_uw.cond)
            gda_pkg::C_ALWAYS:  w_cond = 1'b1;
            gda_pkg::C_IN:      w_cond = w_in_acc;
            gda_pkg::C_REQ:     w_cond = r_req;
            gda_pkg::C_DNEG:    w_cond = (r_days < 18'sd1);
            gda_pkg::C_BLOOP:   w_cond = (w_days_n < 18'sd1);
            gda_pkg::C_FGT:     w_cond = (r_days > w_ylen_s);
            gda_pkg::C_MGT:     w_cond = (r_wm < gda_pkg::MONTH_DEC) && (r_days > w_mlen_s);
            gda_pkg::C_OUTFREE: w_cond = !r_ov || o_rsp.ready;
            default:            w_cond = 1'b0;
        endcase
    end

    // Range check of the year walk: leaving 1..9999 aborts the item
    always_comb begin
        case (w_uw.op)
            gda_pkg::OP_BDEC: w_fail = w_cond && (r_wy <= gda_pkg::YEAR_MIN);
            gda_pkg::OP_BADD: w_fail = w_cond && (r_wy <= gda_pkg::YEAR_MIN);
            gda_pkg::OP_FWD:  w_fail = w_cond && (r_wy >= gda_pkg::YEAR_MAX);
            default:          w_fail = 1'b0;
        endcase
    end

    // Datapath driven by the control word
    always_comb begin
        n_pc    = w_fail ? gda_pkg::STEP_EMIT : (w_cond ? w_uw.jt : w_uw.jf);
        n_ok    = w_fail ? 1'b0 : r_ok;
        n_ov    = (r_ov && o_rsp.ready) ? 1'b0 : r_ov;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_req   = r_req;
        n_sm    = r_sm;
        n_sd    = r_sd;
        n_off   = r_off;
        n_wy    = r_wy;
        n_wm    = r_wm;
        n_days  = r_days;
        n_oyear = r_oyear;
        n_omon  = r_omon;
        n_oday  = r_oday;
        n_oacc  = r_oacc;
        case (w_uw.op)
            gda_pkg::OP_FETCH: begin
                if (w_in_acc) begin
                    n_req = i_req.req_type;
                    n_sm  = i_req.set_month;
                    n_sd  = i_req.set_day;
                    n_off = i_req.day_offset;
                    n_wy  = i_req.req_type ? r_year : i_req.set_year;
                end
            end
            gda_pkg::OP_SET: begin
                n_ok = w_set_ok;
                if (w_set_ok) begin
                    n_year  = r_wy;
                    n_month = r_sm;
                    n_day   = r_sd;
                end
            end
            gda_pkg::OP_DOY: begin
                n_days = $signed({8'd0, w_doy}) + $signed({r_off[16], r_off});
                n_wm   = 4'd1;
            end
            gda_pkg::OP_BDEC: begin
                if (w_cond && !w_fail) begin
                    n_wy = r_wy - 14'd1;
                end
            end
            gda_pkg::OP_BADD: begin
                n_days = w_days_n;
                if (w_cond && !w_fail) begin
                    n_wy = r_wy - 14'd1;
                end
            end
            gda_pkg::OP_FWD: begin
                if (w_cond && !w_fail) begin
                    n_days = r_days - w_ylen_s;
                    n_wy   = r_wy + 14'd1;
                end
            end
            gda_pkg::OP_MON: begin
                if (w_cond) begin
                    n_days = r_days - w_mlen_s;
                    n_wm   = r_wm + 4'd1;
                end
            end
            gda_pkg::OP_COMMIT: begin
                n_year  = r_wy;
                n_month = r_wm;
                n_day   = r_days[4:0];
                n_ok    = 1'b1;
            end
            gda_pkg::OP_EMIT: begin
                if (w_cond) begin
                    n_ov    = 1'b1;
                    n_oyear = r_year;
                    n_omon  = r_month;
                    n_oday  = r_day;
                    n_oacc  = r_ok;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state and stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= gda_pkg::STEP_FETCH;
            r_ok    <= 1'b0;
            r_ov    <= 1'b0;
            r_year  <= gda_pkg::YEAR_MIN;
            r_month <= 4'd1;
            r_day   <= 5'd1;
        end else begin
            r_pc    <= n_pc;
            r_ok    <= n_ok;
            r_ov    <= n_ov;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
        end
    end

    // Working and output payload; leap bit follows the working year
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_sm    <= n_sm;
        r_sd    <= n_sd;
        r_off   <= n_off;
        r_wy    <= n_wy;
        r_wm    <= n_wm;
        r_days  <= n_days;
        r_leap  <= gda_pkg::f_is_leap(n_wy);
        r_oyear <= n_oyear;
        r_omon  <= n_omon;
        r_oday  <= n_oday;
        r_oacc  <= n_oacc;
    end

    assign i_req.ready     = (r_pc == gda_pkg::STEP_FETCH);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.cur_year  = r_oyear;
    assign o_rsp.cur_month = r_omon;
    assign o_rsp.cur_day   = r_oday;
    assign o_rsp.accepted  = r_oacc;

`ifndef SYNTHESIS
    // Stored date is always a real calendar date
    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_year >= gda_pkg::YEAR_MIN) && (r_year <= gda_pkg::YEAR_MAX)
        && (r_day != 5'd0) && (r_day <= gda_pkg::f_mlen(r_month, gda_pkg::f_is_leap(r_year))))
        else $error("stored date out of range");

    // Year walk never leaves the supported range
    a_year_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == gda_pkg::STEP_BADD || r_pc == gda_pkg::STEP_FWD || r_pc == gda_pkg::STEP_MON)
        |-> (r_wy >= gda_pkg::YEAR_MIN) && (r_wy <= gda_pkg::YEAR_MAX))
        else $error("working year out of range");

    // Month walk starts from a day of the year
    a_month_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == gda_pkg::STEP_MON) |-> (r_days >= 18'sd1) && (r_days <= 18'sd366))
        else $error("day count outside one year in month walk");

    // A committed advance is reported as accepted
    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == gda_pkg::STEP_COMMIT) |=> (r_pc == gda_pkg::STEP_EMIT) && r_ok)
        else $error("commit not flagged as accepted");
`endif

endmodule
